### rtl/blraq_pkg.sv
// Shared types, constants and the control-store program for the lazy range-add store.
// Used by blraq_seq, blraq_dp and block_lazy_range_add_point_query.
package blraq_pkg;

  localparam int DEPTH      = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int IDX_W      = 10;
  localparam int BLK_SHIFT  = $clog2(BLOCK_SIZE);
  localparam int BLK_W      = IDX_W - BLK_SHIFT;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int TDATA_W    = 56;
  localparam int UPC_W      = 5;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOAD,
    OP_QRD,
    OP_QOUT,
    OP_SETUP_SAME,
    OP_SETUP_LB,
    OP_SETUP_RB,
    OP_SWEEP,
    OP_DRAIN,
    OP_DRAIN_CLR,
    OP_MID
  } dp_op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEXT,
    C_DISPATCH,
    C_CLR_MORE,
    C_OUT_BUSY,
    C_SWEEP_MORE,
    C_NO_MID,
    C_MID_MORE
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    upc_t   target;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  last_index;
    logic [DATA_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic clr_more;
    logic sweep_more;
    logic no_mid;
    logic mid_more;
  } dp_stat_t;

  typedef struct packed {
    logic     in_fire;
    upc_t     entry;
    logic     out_busy;
    dp_stat_t dp;
  } seq_stat_t;

  localparam upc_t U_CLEAR   = 5'd0;
  localparam upc_t U_IDLE    = 5'd1;
  localparam upc_t U_LOAD    = 5'd2;
  localparam upc_t U_QRD     = 5'd3;
  localparam upc_t U_QOUT    = 5'd4;
  localparam upc_t U_SAME    = 5'd5;
  localparam upc_t U_SAME_SW = 5'd6;
  localparam upc_t U_SAME_DR = 5'd7;
  localparam upc_t U_LB      = 5'd8;
  localparam upc_t U_LB_SW   = 5'd9;
  localparam upc_t U_LB_DR   = 5'd10;
  localparam upc_t U_RB      = 5'd11;
  localparam upc_t U_RB_SW   = 5'd12;
  localparam upc_t U_RB_DR   = 5'd13;
  localparam upc_t U_MID_CHK = 5'd14;
  localparam upc_t U_MID     = 5'd15;
  localparam upc_t U_MID_END = 5'd16;

  function automatic ctl_t ucode(upc_t upc);
    ctl_t w;
    unique case (upc)
      U_CLEAR:   w = '{OP_CLEAR,      C_CLR_MORE,   U_CLEAR};
      U_IDLE:    w = '{OP_ACCEPT,     C_DISPATCH,   U_IDLE};
      U_LOAD:    w = '{OP_LOAD,       C_ALWAYS,     U_IDLE};
      U_QRD:     w = '{OP_QRD,        C_NEXT,       U_IDLE};
      U_QOUT:    w = '{OP_QOUT,       C_OUT_BUSY,   U_IDLE};
      U_SAME:    w = '{OP_SETUP_SAME, C_NEXT,       U_IDLE};
      U_SAME_SW: w = '{OP_SWEEP,      C_SWEEP_MORE, U_SAME_SW};
      U_SAME_DR: w = '{OP_DRAIN,      C_ALWAYS,     U_IDLE};
      U_LB:      w = '{OP_SETUP_LB,   C_NEXT,       U_IDLE};
      U_LB_SW:   w = '{OP_SWEEP,      C_SWEEP_MORE, U_LB_SW};
      U_LB_DR:   w = '{OP_DRAIN_CLR,  C_NEXT,       U_IDLE};
      U_RB:      w = '{OP_SETUP_RB,   C_NEXT,       U_IDLE};
      U_RB_SW:   w = '{OP_SWEEP,      C_SWEEP_MORE, U_RB_SW};
      U_RB_DR:   w = '{OP_DRAIN_CLR,  C_NEXT,       U_IDLE};
      U_MID_CHK: w = '{OP_NONE,       C_NO_MID,     U_IDLE};
      U_MID:     w = '{OP_MID,        C_MID_MORE,   U_MID};
      U_MID_END: w = '{OP_NONE,       C_ALWAYS,     U_IDLE};
      default:   w = '{OP_NONE,       C_ALWAYS,     U_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [BLK_W-1:0] blk_of(logic [IDX_W-1:0] idx);
    return idx[IDX_W-1:BLK_SHIFT];
  endfunction

  function automatic logic [IDX_W-1:0] blk_first(logic [BLK_W-1:0] b);
    return {b, {BLK_SHIFT{1'b0}}};
  endfunction

  function automatic logic [IDX_W-1:0] blk_last(logic [BLK_W-1:0] b);
    logic [IDX_W:0] t;
    t = {1'b0, blk_first(b)} + (IDX_W+1)'(BLOCK_SIZE - 1);
    if (t > (IDX_W+1)'(DEPTH - 1)) begin
      t = (IDX_W+1)'(DEPTH - 1);
    end
    return t[IDX_W-1:0];
  endfunction

  function automatic upc_t entry_of(cmd_e cmd, logic [IDX_W-1:0] first,
                                    logic [IDX_W-1:0] last);
    upc_t e;
    e = U_IDLE;
    unique case (cmd)
      CMD_LOAD: begin
        if ({1'b0, first} < (IDX_W+1)'(DEPTH)) e = U_LOAD;
      end
      CMD_ADD: begin
        if (first <= last && {1'b0, last} < (IDX_W+1)'(DEPTH)) begin
          e = (blk_of(first) == blk_of(last)) ? U_SAME : U_LB;
        end
      end
      CMD_QUERY: e = U_QRD;
      CMD_NONE:  e = U_IDLE;
    endcase
    return e;
  endfunction

endpackage

### rtl/blraq_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on blraq_pkg for the program and the control word layout.
module blraq_seq
  import blraq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ctl_t      ctl_o
);

  upc_t upc_d, upc_q;
  ctl_t ctl;
  logic take;
  upc_t target;

  always_comb begin
    ctl    = ucode(upc_q);
    target = ctl.target;
    unique case (ctl.cond)
      C_ALWAYS:     take = 1'b1;
      C_NEXT:       take = 1'b0;
      C_DISPATCH: begin
        take   = 1'b1;
        target = stat_i.in_fire ? stat_i.entry : U_IDLE;
      end
      C_CLR_MORE:   take = stat_i.dp.clr_more;
      C_OUT_BUSY: begin
        take   = 1'b1;
        target = stat_i.out_busy ? upc_q : ctl.target;
      end
      C_SWEEP_MORE: take = stat_i.dp.sweep_more;
      C_NO_MID:     take = stat_i.dp.no_mid;
      C_MID_MORE:   take = stat_i.dp.mid_more;
      default:      take = 1'b0;
    endcase
    upc_d = take ? target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

### rtl/blraq_dp.sv
// Datapath: element memory, block tag file, sweep counters and the adders.
// Depends on blraq_pkg; driven one micro-operation per cycle by blraq_seq.
module blraq_dp
  import blraq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  input  item_t             item_i,
  output dp_stat_t          stat_o,
  output logic [DATA_W-1:0] qdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] tag_q [NUM_BLOCKS];

  logic [IDX_W-1:0]  idx_d, idx_q, end_d, end_q, pend_addr_q;
  logic              pend_d, pend_q;
  logic [DATA_W-1:0] add_in_d, add_in_q, add_out_d, add_out_q, rdata_q;
  logic [BLK_W-1:0]  mid_d, mid_q, sweep_blk_d, sweep_blk_q;

  logic              we, re, tag_we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata, tag_rd, tag_wdata;
  logic [BLK_W-1:0]  tag_addr, lb, rb;
  logic              in_rng;

  assign lb     = blk_of(item_i.first_index);
  assign rb     = blk_of(item_i.last_index);
  assign tag_rd = tag_q[tag_addr];
  assign in_rng = pend_addr_q >= item_i.first_index && pend_addr_q <= item_i.last_index;

  always_comb begin
    idx_d       = idx_q;
    end_d       = end_q;
    pend_d      = pend_q;
    add_in_d    = add_in_q;
    add_out_d   = add_out_q;
    mid_d       = mid_q;
    sweep_blk_d = sweep_blk_q;
    we          = 1'b0;
    waddr       = pend_addr_q;
    wdata       = rdata_q + (in_rng ? add_in_q : add_out_q);
    re          = 1'b0;
    raddr       = idx_q;
    tag_addr    = sweep_blk_q;
    tag_we      = 1'b0;
    tag_wdata   = '0;
    unique case (op_i)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = '0;
        idx_d = idx_q + IDX_W'(1);
      end
      OP_LOAD: begin
        tag_addr = lb;
        we       = 1'b1;
        waddr    = item_i.first_index;
        wdata    = item_i.amount - tag_rd;
      end
      OP_QRD: begin
        re    = 1'b1;
        raddr = item_i.last_index;
      end
      OP_QOUT: begin
        tag_addr = rb;
      end
      OP_SETUP_SAME: begin
        idx_d     = item_i.first_index;
        end_d     = item_i.last_index;
        add_in_d  = item_i.amount;
        add_out_d = item_i.amount;
      end
      OP_SETUP_LB: begin
        tag_addr    = lb;
        idx_d       = blk_first(lb);
        end_d       = blk_last(lb);
        add_in_d    = tag_rd + item_i.amount;
        add_out_d   = tag_rd;
        sweep_blk_d = lb;
        mid_d       = lb + BLK_W'(1);
      end
      OP_SETUP_RB: begin
        tag_addr    = rb;
        idx_d       = blk_first(rb);
        end_d       = blk_last(rb);
        add_in_d    = tag_rd + item_i.amount;
        add_out_d   = tag_rd;
        sweep_blk_d = rb;
      end
      OP_SWEEP: begin
        we     = pend_q;
        re     = 1'b1;
        pend_d = 1'b1;
        idx_d  = idx_q + IDX_W'(1);
      end
      OP_DRAIN: begin
        we     = pend_q;
        pend_d = 1'b0;
      end
      OP_DRAIN_CLR: begin
        we     = pend_q;
        pend_d = 1'b0;
        tag_we = 1'b1;
      end
      OP_MID: begin
        tag_addr  = mid_q;
        tag_we    = 1'b1;
        tag_wdata = tag_rd + item_i.amount;
        mid_d     = mid_q + BLK_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        tag_q[i] <= '0;
      end
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (tag_we) begin
        tag_q[tag_addr] <= tag_wdata;
      end
      idx_q  <= idx_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q       <= end_d;
    add_in_q    <= add_in_d;
    add_out_q   <= add_out_d;
    mid_q       <= mid_d;
    sweep_blk_q <= sweep_blk_d;
    if (op_i == OP_SWEEP) begin
      pend_addr_q <= idx_q;
    end
  end

  assign stat_o.clr_more   = idx_q != IDX_W'(DEPTH - 1);
  assign stat_o.sweep_more = idx_q != end_q;
  assign stat_o.no_mid     = mid_q == rb;
  assign stat_o.mid_more   = (mid_q + BLK_W'(1)) != rb;

  assign qdata_o = ({1'b0, item_i.last_index} < (IDX_W+1)'(DEPTH)) ? rdata_q + tag_rd : '0;

endmodule

### rtl/block_lazy_range_add_point_query.sv
// Lazy range-add, point-query store: input and output registers around the sequencer.
// Load writes the element less its block tag; a query adds the tag to the element read.
// A range add sweeps its elements in one block, or both edge blocks and the middle tags
// across blocks; sweeps run one read and one write per cycle, middle tags one per cycle.
// Reset: tags clear at once; a pass then zeroes the element memory, tready low.
// Depends on blraq_pkg, blraq_seq and blraq_dp.
module block_lazy_range_add_point_query
  import blraq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // command, first_index, last_index, amount
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [DATA_W-1:0]  m_axis_tdata_o   // element_value
);

  ctl_t              ctl;
  seq_stat_t         seq_stat;
  dp_stat_t          dp_stat;
  item_t             item_q;
  logic              in_fire, out_busy, out_load;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q, qdata;

  assign s_axis_tready_o = ctl.op == OP_ACCEPT;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy        = out_valid_q && !m_axis_tready_i;
  assign out_load        = ctl.op == OP_QOUT && !out_busy;

  assign seq_stat.in_fire  = in_fire;
  assign seq_stat.entry    = entry_of(cmd_e'(s_axis_tdata_i[1:0]), s_axis_tdata_i[11:2],
                                      s_axis_tdata_i[21:12]);
  assign seq_stat.out_busy = out_busy;
  assign seq_stat.dp       = dp_stat;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.first_index <= s_axis_tdata_i[11:2];
      item_q.last_index  <= s_axis_tdata_i[21:12];
      item_q.amount      <= s_axis_tdata_i[53:22];
    end
    if (out_load) begin
      out_data_q <= qdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  blraq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (seq_stat),
    .ctl_o  (ctl)
  );

  blraq_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ctl.op),
    .item_i  (item_q),
    .stat_o  (dp_stat),
    .qdata_o (qdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
